>>> hw/rtl/hfe_pkg.sv
`timescale 1ns / 1ps

package hfe_pkg;

    localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
    localparam logic [7:0] START_CODE_LO  = 8'h00;
    localparam logic [7:0] START_CODE_HI  = 8'hFF;
    localparam logic [7:0] HOST_TO_DEVICE = 8'hD4;
    localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] frame_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
    } t_out_item;

    // classified command byte, front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic [7:0] len_byte;
        logic [7:0] data_chk;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_BEGIN,
        ST_SC0,
        ST_SC1,
        ST_LEN,
        ST_LCS,
        ST_TFI,
        ST_DATA,
        ST_DCS,
        ST_POST
    } t_back_state;

endpackage

>>> hw/rtl/host_frame_encoder.sv
`timescale 1ns / 1ps
// Host frame encoder: wraps command bytes into host-to-device frames.
// Input channel (i_in_valid / o_in_stall / i_in_data): one command byte per
// item plus the frame length, which is sampled on the first byte of a frame.
// Output channel (o_out_valid / i_out_stall / o_out_data): one framed byte per
// item; end_of_frame marks the closing postamble byte.
// A first byte yields 00 00 FF LEN LCS D4 and the byte; a last byte is
// followed by the data checksum and the 00 postamble.
// The front classifies bytes and tracks length and sum, then pushes them into
// a QUEUE_DEPTH-entry queue; the back sequences output bytes, one per cycle
// while the receiver does not stall. The first output byte is registered in
// the queue and then in the output register. Throughput is set by the back
// sequencer: a frame of L bytes becomes L + 8 output bytes; middle bytes are
// accepted one a cycle. Input stalls only while the queue is full.
// When the receiver stalls, the output register holds its byte and the queue
// fills behind it.
// Reset (synchronous, active low) closes any open frame, empties the queue and
// drops the output valid.
module host_frame_encoder
    import hfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    hfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    hfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    hfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

>>> hw/rtl/hfe_front.sv
`timescale 1ns / 1ps

module hfe_front
    import hfe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [7:0] r_remaining, n_remaining;
    logic [7:0] r_sum, n_sum;
    logic       open_frame;
    logic [7:0] eff_len;
    logic [7:0] rem_after;
    logic [7:0] sum_after;
    logic       last;

    assign o_stall    = i_full;
    assign o_push     = i_valid && !i_full;
    assign open_frame = (r_remaining != 8'd0);
    assign eff_len    = (i_data.frame_length == 8'd0) ? 8'd1 : i_data.frame_length;
    assign rem_after  = (open_frame ? r_remaining : eff_len) - 8'd1;
    assign sum_after  = (open_frame ? r_sum : HOST_TO_DEVICE) + i_data.data_byte;
    assign last       = (rem_after == 8'd0);

    always_comb begin
        o_cmd.data_byte = i_data.data_byte;
        o_cmd.first     = !open_frame;
        o_cmd.last      = last;
        o_cmd.len_byte  = eff_len + 8'd1;
        o_cmd.data_chk  = 8'd0 - sum_after;
        n_remaining     = r_remaining;
        n_sum           = r_sum;
        if (o_push) begin
            n_remaining = rem_after;
            n_sum       = last ? 8'd0 : sum_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 8'd0;
            r_sum       <= 8'd0;
        end else begin
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
        end
    end

endmodule

>>> hw/rtl/hfe_queue.sv
`timescale 1ns / 1ps

module hfe_queue
    import hfe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/hfe_back.sv
`timescale 1ns / 1ps

module hfe_back
    import hfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    t_back_state r_state, n_state;
    logic        r_valid;
    t_out_item   r_data;
    logic        load;
    logic        go;
    logic [7:0]  emit_byte;
    logic        emit_eof;

    assign load    = !r_valid || !i_stall;
    assign go      = load && !i_empty;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        emit_byte = i_cmd.data_byte;
        emit_eof  = 1'b0;
        unique case (r_state)
            ST_BEGIN: begin
                if (i_cmd.first) begin
                    emit_byte = PREAMBLE_BYTE;
                    n_state   = ST_SC0;
                end else if (i_cmd.last) begin
                    n_state = ST_DCS;
                end else begin
                    o_pop = go;
                end
            end
            ST_SC0: begin
                emit_byte = START_CODE_LO;
                n_state   = ST_SC1;
            end
            ST_SC1: begin
                emit_byte = START_CODE_HI;
                n_state   = ST_LEN;
            end
            ST_LEN: begin
                emit_byte = i_cmd.len_byte;
                n_state   = ST_LCS;
            end
            ST_LCS: begin
                emit_byte = 8'd0 - i_cmd.len_byte;
                n_state   = ST_TFI;
            end
            ST_TFI: begin
                emit_byte = HOST_TO_DEVICE;
                n_state   = ST_DATA;
            end
            ST_DATA: begin
                if (i_cmd.last) begin
                    n_state = ST_DCS;
                end else begin
                    n_state = ST_BEGIN;
                    o_pop   = go;
                end
            end
            ST_DCS: begin
                emit_byte = i_cmd.data_chk;
                n_state   = ST_POST;
            end
            ST_POST: begin
                emit_byte = POSTAMBLE_BYTE;
                emit_eof  = 1'b1;
                n_state   = ST_BEGIN;
                o_pop     = go;
            end
            default: begin
                n_state = ST_BEGIN;
            end
        endcase
        if (!go) begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BEGIN;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_data.out_byte     <= emit_byte;
            r_data.end_of_frame <= emit_eof;
        end
    end

endmodule
